### hw/rtl/qoi_pkg.sv
// Shared types, chunk tags and a helper function of the QOI pixel stream encoder.
package qoi_pkg;

   // Item operation codes.
   typedef enum logic [1:0] {
      OP_ENCODE  = 2'd0,
      OP_FINISH  = 2'd1,
      OP_RESTART = 2'd2
   } op_type;

   typedef logic [7:0]  byte_type;
   typedef logic [31:0] pixel_type;   // {red, green, blue, alpha}

   // Color index geometry.
   localparam int IDX_DEPTH = 64;
   localparam int IDX_AW    = 6;
   localparam int PIXEL_W   = 32;

   // Result buffer: a run byte plus up to eight chunk bytes.
   localparam int MAX_BYTES = 9;
   localparam int CHUNK_MAX = 8;
   localparam int CNT_W     = 4;

   localparam logic [5:0] RUN_LIMIT  = 6'd62;
   localparam pixel_type  PREV_RESET = 32'h0000_00FF;

   // Chunk tags.
   localparam byte_type TAG_RUN  = 8'hC0;
   localparam byte_type TAG_DIFF = 8'h40;
   localparam byte_type TAG_LUMA = 8'h80;
   localparam byte_type TAG_RGB  = 8'hFE;
   localparam byte_type TAG_RGBA = 8'hFF;

   // Final byte of the end marker; the seven before it are zero.
   localparam byte_type END_LAST = 8'h01;

   // Color index slot: (3r + 5g + 7b + 11a) mod 64, kept to six bits throughout.
   function automatic logic [IDX_AW-1:0] slot_of(input byte_type r, input byte_type g,
                                                 input byte_type b, input byte_type a);
      logic [IDX_AW-1:0] sum;
      sum = r[IDX_AW-1:0] * 6'd3 + g[IDX_AW-1:0] * 6'd5
          + b[IDX_AW-1:0] * 6'd7 + a[IDX_AW-1:0] * 6'd11;
      return sum;
   endfunction

endpackage

### hw/rtl/qoi_pixel_stream_encoder.sv
// Top level of the streaming QOI pixel encoder.
//
// The encoder takes one item per transfer on the req_ channel (encode a pixel, finish the image,
// or restart) and returns the encoded QOI chunk bytes one per transfer on the rsp_ channel, with
// rsp_last_of_item marking the final byte of each item. An accepted item sits in an input stage
// while the 64-entry color index RAM is read; its chunk is then built from that stage and loaded
// into a result buffer of up to nine bytes. A new item is accepted every cycle as long as
// each item yields at most one byte and rsp_ready stays high; an item that yields more bytes holds
// the result buffer until its last byte is handed over, and the input stalls meanwhile. An item
// passes the input stage and then the result buffer before its first byte is presented.
// Restart and run-extending pixels yield no bytes. The color index entries are valid
// flagged in flip-flops, so no clearing pass is needed after reset or restart.
module qoi_pixel_stream_encoder
   import qoi_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [1:0] req_operation,
   input  logic [7:0] req_red,
   input  logic [7:0] req_green,
   input  logic [7:0] req_blue,
   input  logic [7:0] req_alpha,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_last_of_item
);

   // Input stage.
   logic              stg_valid_ff;
   logic [1:0]        stg_op_ff;
   pixel_type         stg_px_ff;
   logic [IDX_AW-1:0] stg_slot_ff;
   logic              byp_hit_ff;
   pixel_type         byp_px_ff;

   // Encoder state.
   pixel_type             prev_ff;
   pixel_type             prev_in;
   logic [5:0]            run_ff;
   logic [5:0]            run_in;
   logic [IDX_DEPTH-1:0]  idx_valid_ff;

   // Result buffer.
   byte_type              buf_ff [MAX_BYTES];
   logic [CNT_W-1:0]      cnt_ff;

   logic              accept;
   logic              fire;
   logic [IDX_AW-1:0] req_slot;
   pixel_type         ram_q;
   pixel_type         entry;
   logic              same_px;
   logic [5:0]        run_inc;
   logic signed [7:0] dr;
   logic signed [7:0] dg;
   logic signed [7:0] db;
   logic signed [8:0] rg;
   logic signed [8:0] bg;
   logic              diff_ok;
   logic              luma_ok;
   byte_type          run_byte;
   byte_type          ch [CHUNK_MAX];
   logic [CNT_W-1:0]  ch_n;
   logic              flush;
   logic              wr_en;
   logic              clear_idx;
   byte_type          out_bytes [MAX_BYTES];
   logic [CNT_W-1:0]  out_n;

   // Handshake: the stage moves on once the buffer is empty or hands over its last byte.
   assign fire      = stg_valid_ff && ((cnt_ff == '0) ||
                                       ((cnt_ff == CNT_W'(1)) && rsp_ready));
   assign req_ready = !stg_valid_ff || fire;
   assign accept    = req_valid && req_ready;
   assign req_slot  = slot_of(req_red, req_green, req_blue, req_alpha);

   // Color index storage, read when an item is accepted.
   qoi_ram #(
      .WIDTH(PIXEL_W),
      .DEPTH(IDX_DEPTH)
   ) u_index (
      .clock  (clock),
      .wr_en  (fire && wr_en),
      .wr_addr(stg_slot_ff),
      .wr_data(stg_px_ff),
      .rd_en  (accept),
      .rd_addr(req_slot),
      .rd_data(ram_q)
   );

   // Index entry as seen by the staged item; a write on its accept edge is forwarded.
   assign entry = idx_valid_ff[stg_slot_ff] ? (byp_hit_ff ? byp_px_ff : ram_q) : '0;

   // Channel deltas, wrapped to eight bits.
   assign same_px = (stg_px_ff == prev_ff);
   assign run_inc = run_ff + 6'd1;
   assign dr      = signed'(stg_px_ff[31:24] - prev_ff[31:24]);
   assign dg      = signed'(stg_px_ff[23:16] - prev_ff[23:16]);
   assign db      = signed'(stg_px_ff[15:8]  - prev_ff[15:8]);
   assign rg      = {dr[7], dr} - {dg[7], dg};
   assign bg      = {db[7], db} - {dg[7], dg};
   assign diff_ok = (dr >= -8'sd2) && (dr <= 8'sd1) && (dg >= -8'sd2) && (dg <= 8'sd1) &&
                    (db >= -8'sd2) && (db <= 8'sd1);
   assign luma_ok = (dg >= -8'sd32) && (dg <= 8'sd31) && (rg >= -9'sd8) && (rg <= 9'sd7) &&
                    (bg >= -9'sd8) && (bg <= 9'sd7);
   assign run_byte = TAG_RUN | {2'b00, run_ff - 6'd1};

   // Chunk selection and next state for the staged item.
   always_comb begin
      for (int i = 0; i < CHUNK_MAX; i++) begin
         ch[i] = '0;
      end
      ch_n      = '0;
      flush     = 1'b0;
      wr_en     = 1'b0;
      clear_idx = 1'b0;
      run_in    = run_ff;
      prev_in   = prev_ff;
      case (stg_op_ff)
         OP_ENCODE: begin
            if (same_px) begin
               if (run_inc >= RUN_LIMIT) begin
                  ch[0]  = TAG_RUN | {2'b00, RUN_LIMIT - 6'd1};
                  ch_n   = CNT_W'(1);
                  run_in = '0;
               end else begin
                  run_in = run_inc;
               end
            end else begin
               flush   = (run_ff != '0);
               run_in  = '0;
               prev_in = stg_px_ff;
               if (entry == stg_px_ff) begin
                  ch[0] = {2'b00, stg_slot_ff};
                  ch_n  = CNT_W'(1);
               end else begin
                  wr_en = 1'b1;
                  if (stg_px_ff[7:0] != prev_ff[7:0]) begin
                     ch[0] = TAG_RGBA;
                     ch[1] = stg_px_ff[31:24];
                     ch[2] = stg_px_ff[23:16];
                     ch[3] = stg_px_ff[15:8];
                     ch[4] = stg_px_ff[7:0];
                     ch_n  = CNT_W'(5);
                  end else if (diff_ok) begin
                     ch[0] = TAG_DIFF | {2'b00, dr[1:0] + 2'd2, dg[1:0] + 2'd2,
                                         db[1:0] + 2'd2};
                     ch_n  = CNT_W'(1);
                  end else if (luma_ok) begin
                     ch[0] = TAG_LUMA | {2'b00, dg[5:0] + 6'd32};
                     ch[1] = {rg[3:0] + 4'd8, bg[3:0] + 4'd8};
                     ch_n  = CNT_W'(2);
                  end else begin
                     ch[0] = TAG_RGB;
                     ch[1] = stg_px_ff[31:24];
                     ch[2] = stg_px_ff[23:16];
                     ch[3] = stg_px_ff[15:8];
                     ch_n  = CNT_W'(4);
                  end
               end
            end
         end
         OP_FINISH: begin
            flush  = (run_ff != '0);
            run_in = '0;
            ch[CHUNK_MAX-1] = END_LAST;
            ch_n   = CNT_W'(CHUNK_MAX);
         end
         OP_RESTART: begin
            run_in    = '0;
            prev_in   = PREV_RESET;
            clear_idx = 1'b1;
         end
         default: begin
         end
      endcase
   end

   // A pending run byte goes ahead of the chunk bytes.
   always_comb begin
      out_bytes[0] = flush ? run_byte : ch[0];
      for (int i = 1; i < CHUNK_MAX; i++) begin
         out_bytes[i] = flush ? ch[i-1] : ch[i];
      end
      out_bytes[MAX_BYTES-1] = flush ? ch[CHUNK_MAX-1] : '0;
      out_n = ch_n + {{(CNT_W-1){1'b0}}, flush};
   end

   // Input stage and forwarding of the write made on the accept edge.
   always_ff @(posedge clock) begin
      if (reset) begin
         stg_valid_ff <= 1'b0;
      end else if (accept) begin
         stg_valid_ff <= 1'b1;
      end else if (fire) begin
         stg_valid_ff <= 1'b0;
      end
      if (accept) begin
         stg_op_ff   <= req_operation;
         stg_px_ff   <= {req_red, req_green, req_blue, req_alpha};
         stg_slot_ff <= req_slot;
         byp_hit_ff  <= fire && wr_en && (stg_slot_ff == req_slot);
         byp_px_ff   <= stg_px_ff;
      end
   end

   // Encoder state update.
   always_ff @(posedge clock) begin
      if (reset) begin
         prev_ff      <= PREV_RESET;
         run_ff       <= '0;
         idx_valid_ff <= '0;
      end else if (fire) begin
         prev_ff <= prev_in;
         run_ff  <= run_in;
         if (clear_idx) begin
            idx_valid_ff <= '0;
         end else if (wr_en) begin
            idx_valid_ff[stg_slot_ff] <= 1'b1;
         end
      end
   end

   // Result buffer: loaded by the stage, shifted by one byte per transfer.
   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else if (fire) begin
         cnt_ff <= out_n;
      end else if (rsp_valid && rsp_ready) begin
         cnt_ff <= cnt_ff - CNT_W'(1);
      end
      if (fire) begin
         for (int i = 0; i < MAX_BYTES; i++) begin
            buf_ff[i] <= out_bytes[i];
         end
      end else if (rsp_valid && rsp_ready) begin
         for (int i = 0; i < MAX_BYTES - 1; i++) begin
            buf_ff[i] <= buf_ff[i+1];
         end
      end
   end

   assign rsp_valid        = (cnt_ff != '0);
   assign rsp_out_byte     = buf_ff[0];
   assign rsp_last_of_item = (cnt_ff == CNT_W'(1));

endmodule

### hw/rtl/qoi_ram.sv
// Generic single-write, single-read RAM with registered read data.
module qoi_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port and registered read port; a read at a written address returns old data.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
